// ===== design/imu_angle_frame_parser_assert.svh =====
// Assertion macros shared by the angle frame parser RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IMU_ANGLE_FRAME_PARSER_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IAFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define IAFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ===== design/iafp_pkg.sv =====
// Package of the angle frame parser: frame layout constants, register
// indexes and the frame view struct. No dependencies.
`default_nettype none

package iafp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned FRAME_CELLS = 9;
  localparam int unsigned ANGLE_BYTES = 6;

  localparam logic [POS_W-1:0] POS_SYNC  = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd10;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h53;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t                      type_seen;
    byte_t [ANGLE_BYTES-1:0]    angle;
  } frame_view_t;

endpackage

`default_nettype wire

// ===== design/iafp_byte_cell.sv =====
// One storage cell of the frame shift row: holds one received byte and
// passes it to the next cell on every shift. Uses iafp_pkg.
`default_nettype none

module iafp_byte_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire iafp_pkg::byte_t d_in,
  output iafp_pkg::byte_t    q
);
  import iafp_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/iafp_cell_row.sv =====
// Row of byte cells holding frame bytes 1 to 9, newest byte in cell zero.
// Depends on iafp_pkg and iafp_byte_cell.
`default_nettype none

module iafp_cell_row (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire iafp_pkg::byte_t d_in,
  output iafp_pkg::frame_view_t view
);
  import iafp_pkg::*;

  byte_t cell_q [FRAME_CELLS];

  for (genvar i = 0; i < FRAME_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      iafp_byte_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (d_in),
        .q        (cell_q[i])
      );
    end else begin : g_tail
      iafp_byte_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  // Frame byte k sits in cell 9 - k once byte 9 has been shifted in.
  always_comb begin
    view.type_seen = cell_q[FRAME_CELLS-1];
    for (int j = 0; j < ANGLE_BYTES; j++) begin
      view.angle[j] = cell_q[FRAME_CELLS-2-j];
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_angle_frame_parser.sv =====
// Top level of the angle frame parser: sync search, checksum, type check and
// output register. Depends on iafp_pkg, iafp_cell_row and the assertion header.
//
//   channel  direction  request payload
//   s_*      in         rx_byte in s_tdata
//   m_*      out        roll, pitch and yaw in m_tdata
//   cfg_*    in         register index and write data
//
// A new request is taken each cycle while the input is not stalled.
// A frame that passes both checks is presented in the cycle after its last byte.
// Input stalls only while a result waits in the output register and m_tready is low.
// Reset clears the frame position, the checksum and the output valid flag.
`default_nettype none
`include "imu_angle_frame_parser_assert.svh"

module imu_angle_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [15:0] roll_raw, [31:16] pitch_raw, [47:32] yaw_raw
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [iafp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import iafp_pkg::*;

  byte_t            sync_byte;
  byte_t            frame_type;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  byte_t            sum;
  byte_t            sum_next;
  logic             in_fire;
  logic             pos_final;
  logic             shift_en;
  logic             emit;
  frame_view_t      view;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign pos_final = (pos >= POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_RESET;
      frame_type <= TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:  sync_byte  <= cfg_data;
        CFG_FRAME_TYPE: frame_type <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_next = pos;
    sum_next = sum;
    shift_en = 1'b0;
    emit     = 1'b0;
    if (in_fire) begin
      priority if (pos == POS_SYNC) begin
        if (s_tdata == sync_byte) begin
          pos_next = POS_FIRST;
          sum_next = s_tdata;
        end
      end else if (!pos_final) begin
        pos_next = pos + POS_FIRST;
        sum_next = sum + s_tdata;
        shift_en = 1'b1;
      end else begin
        pos_next = POS_SYNC;
        emit     = (sum == s_tdata) && (view.type_seen == frame_type);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_SYNC;
      sum <= '0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  iafp_cell_row u_row (
    .clk      (clk),
    .shift_en (shift_en),
    .d_in     (s_tdata),
    .view     (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {view.angle[5], view.angle[4], view.angle[3],
                  view.angle[2], view.angle[1], view.angle[0]};
    end
  end

  `IAFP_ASSERT_NOW(a_pos_range, 1'b1, pos <= POS_LAST)
  `IAFP_ASSERT_NOW(a_result_from_final, $rose(m_tvalid), $past(in_fire && pos_final))
  `IAFP_ASSERT_NEXT(a_drop_unsynced, in_fire && (pos == POS_SYNC) && (s_tdata != sync_byte),
                    pos == POS_SYNC)

endmodule

`default_nettype wire
